// ===== hdl/rbes_pkg.sv =====
// shared types, constants and fixed-point helpers for the 2d euler step block
package rbes_pkg;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] OP_FORCE  = 2'd0;
  localparam logic [1:0] OP_TARGET = 2'd1;
  localparam logic [1:0] OP_SPIN   = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [2:0] CFG_DT    = 3'd0;
  localparam logic [2:0] CFG_IMASS = 3'd1;
  localparam logic [2:0] CFG_LDRAG = 3'd2;
  localparam logic [2:0] CFG_ADRAG = 3'd3;
  localparam logic [2:0] CFG_GSCL  = 3'd4;
  localparam logic [2:0] CFG_GX    = 3'd5;
  localparam logic [2:0] CFG_GY    = 3'd6;

  localparam logic [16:0]        RST_DT    = 17'd1311;
  localparam logic [30:0]        RST_IMASS = 31'd65536;
  localparam logic [30:0]        RST_LDRAG = 31'd0;
  localparam logic [30:0]        RST_ADRAG = 31'd0;
  localparam logic signed [31:0] RST_GSCL  = 32'sd65536;
  localparam logic signed [31:0] RST_GX    = 32'sd0;
  localparam logic signed [31:0] RST_GY    = -32'sd642908;

  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } cmd_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat_sum(input logic signed [32:0] s);
    sat_t r;
    if (s[32] != s[31]) begin
      r.sat = 1'b1;
      r.val = s[32] ? Q_MIN : Q_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = s[31:0];
    end
    return r;
  endfunction

  // floor shift by 16 of a q32.32 product, then clip
  function automatic sat_t q_scale(input logic signed [63:0] p);
    sat_t r;
    if ((&p[63:47]) || !(|p[63:47])) begin
      r.sat = 1'b0;
      r.val = p[47:16];
    end else begin
      r.sat = 1'b1;
      r.val = p[63] ? Q_MIN : Q_MAX;
    end
    return r;
  endfunction

endpackage

// ===== hdl/rbes_front.sv =====
// input acceptance and command queue
module rbes_front import rbes_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_value_x,
  input  logic signed [31:0] in_value_y,
  output logic               q_valid,
  output cmd_t               q_cmd,
  input  logic               q_pop
);

  cmd_t              mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  logic              pop;
  cmd_t              cmd_in;

  assign in_stall = (cnt_r == QCNT_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = mem[rd_ptr_r];

  always_comb begin
    cmd_in.op = in_operation;
    cmd_in.vx = in_value_x;
    cmd_in.vy = in_value_y;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/rbes_back.sv =====
// body state, configuration and tick sequencer around one shared multiplier
module rbes_back import rbes_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_position_x,
  output logic signed [31:0] out_position_y,
  output logic signed [31:0] out_angle,
  output logic signed [31:0] out_velocity_x,
  output logic signed [31:0] out_velocity_y,
  output logic signed [31:0] out_spin_rate,
  output logic               out_saturated
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam logic [3:0] ST_FX_IM  = 4'd0;
  localparam logic [3:0] ST_GX_GS  = 4'd1;
  localparam logic [3:0] ST_FY_IM  = 4'd2;
  localparam logic [3:0] ST_GY_GS  = 4'd3;
  localparam logic [3:0] ST_SPIN   = 4'd4;
  localparam logic [3:0] ST_ANGLE  = 4'd5;
  localparam logic [3:0] ST_VX     = 4'd6;
  localparam logic [3:0] ST_VY     = 4'd7;
  localparam logic [3:0] ST_FACTOR = 4'd8;
  localparam logic [3:0] ST_DVX    = 4'd9;
  localparam logic [3:0] ST_DVY    = 4'd10;
  localparam logic [3:0] ST_PX     = 4'd11;
  localparam logic [3:0] ST_PY     = 4'd12;

  logic [16:0]        dt_r;
  logic [30:0]        imass_r;
  logic [30:0]        ldrag_r;
  logic [30:0]        adrag_r;
  logic signed [31:0] gscl_r;
  logic signed [31:0] gx_r;
  logic signed [31:0] gy_r;

  logic signed [31:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r;
  logic signed [31:0] tgt_x_r, tgt_y_r, frc_x_r, frc_y_r;
  logic signed [31:0] spin_r, angle_r;
  logic signed [31:0] ax_r, ay_r, fac_r;
  logic signed [63:0] prod_r;
  logic               sat_r;
  logic [1:0]         state_r;
  logic [3:0]         step_r;

  logic               out_valid_r;
  logic signed [31:0] out_px_r, out_py_r, out_ang_r, out_vx_r, out_vy_r, out_spin_r;
  logic               out_sat_r;

  logic               out_free;
  logic               is_tick;
  logic               load_out;
  logic signed [31:0] ma, mb;
  logic signed [31:0] dt_ext;
  logic signed [31:0] add_a;
  logic               add_sub;
  logic signed [32:0] sum_ext;
  sat_t               ps;
  sat_t               sum;
  sat_t               fx_sum, fy_sum, dx_sub, dy_sub;
  logic               drag_big;
  logic               step_sat;
  logic signed [31:0] spin_src;
  logic               sat_src;

  assign out_free = !out_valid_r || !out_stall;
  assign is_tick  = (q_cmd.op == OP_TICK);
  assign q_pop    = (state_r == S_IDLE) && q_valid && out_free;
  assign load_out = (q_pop && !is_tick) || ((state_r == S_EMIT) && out_free);
  assign dt_ext   = {15'd0, dt_r};
  assign drag_big = ({1'b0, adrag_r} > Q_ONE);

  assign fx_sum = sat_sum({frc_x_r[31], frc_x_r} + {q_cmd.vx[31], q_cmd.vx});
  assign fy_sum = sat_sum({frc_y_r[31], frc_y_r} + {q_cmd.vy[31], q_cmd.vy});
  assign dx_sub = sat_sum({tgt_x_r[31], tgt_x_r} - {vel_x_r[31], vel_x_r});
  assign dy_sub = sat_sum({tgt_y_r[31], tgt_y_r} - {vel_y_r[31], vel_y_r});

  always_comb begin
    case (step_r)
      ST_FX_IM:  begin ma = frc_x_r;          mb = {1'b0, imass_r}; end
      ST_GX_GS:  begin ma = gx_r;             mb = gscl_r;          end
      ST_FY_IM:  begin ma = frc_y_r;          mb = {1'b0, imass_r}; end
      ST_GY_GS:  begin ma = gy_r;             mb = gscl_r;          end
      ST_SPIN:   begin ma = {1'b0, adrag_r};  mb = spin_r;          end
      ST_ANGLE:  begin ma = spin_r;           mb = dt_ext;          end
      ST_VX:     begin ma = ax_r;             mb = dt_ext;          end
      ST_VY:     begin ma = ay_r;             mb = dt_ext;          end
      ST_FACTOR: begin ma = dt_ext;           mb = {1'b0, ldrag_r}; end
      ST_DVX:    begin ma = ax_r;             mb = fac_r;           end
      ST_DVY:    begin ma = ay_r;             mb = fac_r;           end
      ST_PX:     begin ma = vel_x_r;          mb = dt_ext;          end
      ST_PY:     begin ma = vel_y_r;          mb = dt_ext;          end
      default:   begin ma = '0;               mb = '0;              end
    endcase
  end

  assign ps = q_scale(prod_r);

  always_comb begin
    add_sub = 1'b0;
    case (step_r)
      ST_FX_IM, ST_GX_GS: add_a = ax_r;
      ST_FY_IM, ST_GY_GS: add_a = ay_r;
      ST_SPIN:   begin add_a = spin_r; add_sub = 1'b1; end
      ST_ANGLE:  add_a = angle_r;
      ST_VX:     add_a = vel_x_r;
      ST_VY:     add_a = vel_y_r;
      ST_FACTOR: begin add_a = Q_ONE; add_sub = 1'b1; end
      ST_PX:     add_a = pos_x_r;
      ST_PY:     add_a = pos_y_r;
      default:   add_a = '0;
    endcase
  end

  assign sum_ext = add_sub ? ({add_a[31], add_a} - {ps.val[31], ps.val})
                           : ({add_a[31], add_a} + {ps.val[31], ps.val});
  assign sum     = sat_sum(sum_ext);

  always_comb begin
    case (step_r)
      ST_SPIN:        step_sat = drag_big ? 1'b0 : (ps.sat | sum.sat);
      ST_DVX, ST_DVY: step_sat = ps.sat;
      default:        step_sat = ps.sat | sum.sat;
    endcase
  end

  assign spin_src = (q_pop && (q_cmd.op == OP_SPIN)) ? q_cmd.vx : spin_r;
  assign sat_src  = q_pop ? ((q_cmd.op == OP_FORCE) && (fx_sum.sat || fy_sum.sat)) : sat_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r    <= RST_DT;
      imass_r <= RST_IMASS;
      ldrag_r <= RST_LDRAG;
      adrag_r <= RST_ADRAG;
      gscl_r  <= RST_GSCL;
      gx_r    <= RST_GX;
      gy_r    <= RST_GY;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DT:    dt_r    <= cfg_data[16:0];
        CFG_IMASS: imass_r <= cfg_data[30:0];
        CFG_LDRAG: ldrag_r <= cfg_data[30:0];
        CFG_ADRAG: adrag_r <= cfg_data[30:0];
        CFG_GSCL:  gscl_r  <= cfg_data;
        CFG_GX:    gx_r    <= cfg_data;
        CFG_GY:    gy_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_r <= ma * mb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      sat_r   <= 1'b0;
      pos_x_r <= '0;
      pos_y_r <= '0;
      vel_x_r <= '0;
      vel_y_r <= '0;
      tgt_x_r <= '0;
      tgt_y_r <= '0;
      frc_x_r <= '0;
      frc_y_r <= '0;
      spin_r  <= '0;
      angle_r <= '0;
      ax_r    <= '0;
      ay_r    <= '0;
      fac_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            case (q_cmd.op)
              OP_FORCE: begin
                frc_x_r <= fx_sum.val;
                frc_y_r <= fy_sum.val;
              end
              OP_TARGET: begin
                tgt_x_r <= q_cmd.vx;
                tgt_y_r <= q_cmd.vy;
              end
              OP_SPIN: spin_r <= q_cmd.vx;
              default: begin
                ax_r    <= dx_sub.val;
                ay_r    <= dy_sub.val;
                sat_r   <= dx_sub.sat | dy_sub.sat;
                step_r  <= ST_FX_IM;
                state_r <= S_MUL;
              end
            endcase
          end
        end
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          sat_r <= sat_r | step_sat;
          case (step_r)
            ST_FX_IM, ST_GX_GS, ST_VX: ax_r <= sum.val;
            ST_FY_IM, ST_GY_GS, ST_VY: ay_r <= sum.val;
            ST_SPIN:   spin_r  <= drag_big ? '0 : sum.val;
            ST_ANGLE:  angle_r <= sum.val;
            ST_FACTOR: fac_r   <= sum.val;
            ST_DVX:    vel_x_r <= ps.val;
            ST_DVY:    vel_y_r <= ps.val;
            ST_PX:     pos_x_r <= sum.val;
            ST_PY: begin
              pos_y_r <= sum.val;
              frc_x_r <= '0;
              frc_y_r <= '0;
            end
            default: ;
          endcase
          if (step_r == ST_PY) begin
            state_r <= S_EMIT;
          end else begin
            step_r  <= step_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_px_r   <= pos_x_r;
      out_py_r   <= pos_y_r;
      out_ang_r  <= angle_r;
      out_vx_r   <= vel_x_r;
      out_vy_r   <= vel_y_r;
      out_spin_r <= spin_src;
      out_sat_r  <= sat_src;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_position_x = out_px_r;
  assign out_position_y = out_py_r;
  assign out_angle      = out_ang_r;
  assign out_velocity_x = out_vx_r;
  assign out_velocity_y = out_vy_r;
  assign out_spin_rate  = out_spin_r;
  assign out_saturated  = out_sat_r;

endmodule

// ===== hdl/rigid_body_euler_step_2d.sv =====
// top level of the 2d rigid body euler step block
// force, target and spin transactions pass from the queue into the output register;
// a tick transaction runs 13 products in turn on one 32x32 multiplier via S_MUL, S_ACC
// one non-tick transaction per cycle unless out_stall; the back end takes none mid-tick
// a 2-entry queue takes input while the back end works or a result waits
// reset: synchronous rst_n clears body state, empties the queue, loads register defaults
module rigid_body_euler_step_2d import rbes_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_value_x,
  input  logic signed [31:0] in_value_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_position_x,
  output logic signed [31:0] out_position_y,
  output logic signed [31:0] out_angle,
  output logic signed [31:0] out_velocity_x,
  output logic signed [31:0] out_velocity_y,
  output logic signed [31:0] out_spin_rate,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  rbes_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_value_x   (in_value_x),
    .in_value_y   (in_value_y),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  rbes_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_position_x (out_position_x),
    .out_position_y (out_position_y),
    .out_angle      (out_angle),
    .out_velocity_x (out_velocity_x),
    .out_velocity_y (out_velocity_y),
    .out_spin_rate  (out_spin_rate),
    .out_saturated  (out_saturated)
  );

endmodule

// ===== bench/rigid_body_euler_step_2d_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the 2d rigid body euler step block
module rigid_body_euler_step_2d_test;
  import rbes_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 110;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int STEADY_PHASE = 3;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] angle;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] spin;
    logic               sat;
  } body_report_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  sel;
    logic [31:0] vx;
    logic [31:0] vy;
    bit          known;
    logic [31:0] want_spin;
    logic        want_sat;
  } plan_row_t;

  localparam int N_ROWS = 28;

  plan_row_t plan [N_ROWS] = '{
    '{ROW_ITEM, 3'(OP_SPIN),   Q_MAX,          Q_MIN,          1'b1, Q_MAX,  1'b0},
    '{ROW_ITEM, 3'(OP_SPIN),   Q_MIN,          Q_MAX,          1'b1, Q_MIN,  1'b0},
    '{ROW_ITEM, 3'(OP_SPIN),   32'sd0,         32'sd0,         1'b1, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_TARGET), Q_MAX,          Q_MIN,          1'b1, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_FORCE),  Q_MAX,          Q_MAX,          1'b1, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_FORCE),  32'sd1,         32'sd1,         1'b1, 32'sd0, 1'b1},
    '{ROW_ITEM, 3'(OP_FORCE),  Q_MIN,          Q_MIN,          1'b1, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_FORCE),  Q_MIN,          Q_MIN,          1'b1, 32'sd0, 1'b1},
    '{ROW_ITEM, 3'(OP_TICK),   32'sd0,         32'sd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_TARGET), 32'sd0,         32'sd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_TICK),   Q_MAX,          Q_MIN,          1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_SPIN),   32'sd5898240,   Q_MIN,          1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_TICK),   32'sd0,         32'sd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_CFG,  CFG_ADRAG,     32'd65536,      32'sd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_TICK),   32'sd0,         32'sd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_SPIN),   32'sd5898240,   32'sd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_CFG,  CFG_ADRAG,     32'd65537,      32'sd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_TICK),   32'sd0,         32'sd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_CFG,  CFG_LDRAG,     32'h7FFF_FFFF,  32'sd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_TARGET), 32'sd196608,    -32'sd131072,   1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_TICK),   32'sd0,         32'sd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_FORCE),  32'sd6553600,   -32'sd6553600,  1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_TICK),   32'sd0,         32'sd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_CFG,  CFG_DT,        32'd65536,      32'sd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_CFG,  CFG_ADRAG,     32'd32768,      32'sd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_SPIN),   Q_MAX,          32'sd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_TICK),   32'sd0,         32'sd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 3'(OP_TICK),   32'sd0,         32'sd0,         1'b0, 32'sd0, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_operation;
  logic signed [31:0] in_value_x;
  logic signed [31:0] in_value_y;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_position_x;
  logic signed [31:0] out_position_y;
  logic signed [31:0] out_angle;
  logic signed [31:0] out_velocity_x;
  logic signed [31:0] out_velocity_y;
  logic signed [31:0] out_spin_rate;
  logic               out_saturated;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  // body state and register copies kept by the predictor
  longint dt_q, imass_q, ldrag_q, adrag_q, gscale_q, grav_x_q, grav_y_q;
  longint pos_x, pos_y, vel_x, vel_y, tgt_x, tgt_y, frc_x, frc_y, spin, angle;
  bit     clipped;

  body_report_t pending_reports[$];
  int           mismatches = 0;
  int           items_sent = 0;
  bit           steady = 1'b0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;

  rigid_body_euler_step_2d u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_value_x     (in_value_x),
    .in_value_y     (in_value_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_position_x (out_position_x),
    .out_position_y (out_position_y),
    .out_angle      (out_angle),
    .out_velocity_x (out_velocity_x),
    .out_velocity_y (out_velocity_y),
    .out_spin_rate  (out_spin_rate),
    .out_saturated  (out_saturated),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint fx_clip(input longint v);
    if (v > longint'(Q_MAX)) begin
      clipped = 1'b1;
      return longint'(Q_MAX);
    end
    if (v < longint'(Q_MIN)) begin
      clipped = 1'b1;
      return longint'(Q_MIN);
    end
    return v;
  endfunction

  // floor of the q16.16 product
  function automatic longint fx_mul(input longint a, input longint b);
    return fx_clip((a * b) >>> 16);
  endfunction

  function automatic longint fx_add(input longint a, input longint b);
    return fx_clip(a + b);
  endfunction

  function automatic longint fx_sub(input longint a, input longint b);
    return fx_clip(a - b);
  endfunction

  function automatic body_report_t advance_body(input logic [1:0] op,
                                                input logic signed [31:0] vx,
                                                input logic signed [31:0] vy);
    longint       ax, ay, nx, ny, factor;
    body_report_t r;
    clipped = 1'b0;
    case (op)
      OP_FORCE: begin
        frc_x = fx_add(frc_x, vx);
        frc_y = fx_add(frc_y, vy);
      end
      OP_TARGET: begin
        tgt_x = vx;
        tgt_y = vy;
      end
      OP_SPIN: begin
        spin = vx;
      end
      default: begin
        ax = fx_add(fx_add(fx_sub(tgt_x, vel_x), fx_mul(frc_x, imass_q)),
                    fx_mul(grav_x_q, gscale_q));
        ay = fx_add(fx_add(fx_sub(tgt_y, vel_y), fx_mul(frc_y, imass_q)),
                    fx_mul(grav_y_q, gscale_q));
        if (adrag_q > longint'(Q_ONE)) begin
          spin = 0;
        end else begin
          spin = fx_sub(spin, fx_mul(adrag_q, spin));
        end
        angle  = fx_add(angle, fx_mul(spin, dt_q));
        nx     = fx_add(vel_x, fx_mul(ax, dt_q));
        ny     = fx_add(vel_y, fx_mul(ay, dt_q));
        factor = fx_sub(longint'(Q_ONE), fx_mul(dt_q, ldrag_q));
        vel_x  = fx_mul(nx, factor);
        vel_y  = fx_mul(ny, factor);
        pos_x  = fx_add(pos_x, fx_mul(vel_x, dt_q));
        pos_y  = fx_add(pos_y, fx_mul(vel_y, dt_q));
        frc_x  = 0;
        frc_y  = 0;
      end
    endcase
    r.pos_x = pos_x[31:0];
    r.pos_y = pos_y[31:0];
    r.angle = angle[31:0];
    r.vel_x = vel_x[31:0];
    r.vel_y = vel_y[31:0];
    r.spin  = spin[31:0];
    r.sat   = clipped;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2, 3: return $urandom;
      default: return int'($urandom_range(0, 1310720)) - 655360;
    endcase
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic offer(input logic [1:0] op, input logic signed [31:0] vx,
                       input logic signed [31:0] vy, input bit known,
                       input body_report_t typed);
    body_report_t predicted;
    if (!steady && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value_x   <= vx;
    in_value_y   <= vy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_body(op, vx, vy);
    pending_reports.push_back(known ? typed : predicted);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DT:    dt_q     = longint'(data[16:0]);
      CFG_IMASS: imass_q  = longint'(data[30:0]);
      CFG_LDRAG: ldrag_q  = longint'(data[30:0]);
      CFG_ADRAG: adrag_q  = longint'(data[30:0]);
      CFG_GSCL:  gscale_q = longint'($signed(data));
      CFG_GX:    grav_x_q = longint'($signed(data));
      CFG_GY:    grav_y_q = longint'($signed(data));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_phase(input int p);
    logic [31:0] dt, im, ld, ad, gs, gx, gy;
    dt = $urandom_range(0, 65536);
    im = $urandom_range(0, 262144);
    ld = $urandom_range(0, 32768);
    ad = $urandom_range(0, 70000);
    gs = pick_value();
    gx = pick_value();
    gy = pick_value();
    case (p)
      0: begin
        dt = 32'(RST_DT);
        gs = RST_GSCL;
        gy = RST_GY;
      end
      1: begin
        dt = '0;
        im = '0;
        ld = '0;
        ad = '0;
      end
      2: begin
        dt = 32'd65536;
        im = 32'h7FFF_FFFF;
        ld = 32'h7FFF_FFFF;
        ad = 32'h7FFF_FFFF;
        gs = Q_MIN;
        gx = Q_MAX;
        gy = Q_MIN;
      end
      3: begin
        dt = 32'(RST_DT);
        ad = 32'd65537;
        ld = 32'h7FFF_FFFF;
        gs = Q_MAX;
        gx = Q_MIN;
        gy = Q_MAX;
      end
      4: begin
        ad = 32'd65536;
        gs = '0;
      end
      5: begin
        im = $urandom & 32'h7FFF_FFFF;
        ld = $urandom & 32'h7FFF_FFFF;
      end
      default: ;
    endcase
    drain();
    cfg_write(CFG_DT, dt);
    cfg_write(CFG_IMASS, im);
    cfg_write(CFG_LDRAG, ld);
    cfg_write(CFG_ADRAG, ad);
    cfg_write(CFG_GSCL, gs);
    cfg_write(CFG_GX, gx);
    cfg_write(CFG_GY, gy);
  endtask

  always @(posedge clk) begin : result_monitor
    body_report_t seen, want;
    if (out_valid && !out_stall) begin
      seen = '{out_position_x, out_position_y, out_angle, out_velocity_x,
               out_velocity_y, out_spin_rate, out_saturated};
      if (pending_reports.size() == 0) begin
        $display("%0t ns: result transaction with nothing pending", $time);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("position_x", want.pos_x, seen.pos_x);
        check_field("position_y", want.pos_y, seen.pos_y);
        check_field("angle", want.angle, seen.angle);
        check_field("velocity_x", want.vel_x, seen.vel_x);
        check_field("velocity_y", want.vel_y, seen.vel_y);
        check_field("spin_rate", want.spin, seen.spin);
        check_field("saturated", 32'(want.sat), 32'(seen.sat));
      end
    end
    // one long hold-off so the input side backs up
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && items_sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 26);
    end
  end

  initial begin : watchdog
    int n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    body_report_t typed;
    logic [1:0]   op;
    int           r;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_FORCE;
    in_value_x   <= '0;
    in_value_y   <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_DT;
    cfg_data     <= '0;
    dt_q     = longint'(RST_DT);
    imass_q  = longint'(RST_IMASS);
    ldrag_q  = longint'(RST_LDRAG);
    adrag_q  = longint'(RST_ADRAG);
    gscale_q = longint'(RST_GSCL);
    grav_x_q = longint'(RST_GX);
    grav_y_q = longint'(RST_GY);
    pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0;
    tgt_x = 0; tgt_y = 0; frc_x = 0; frc_y = 0;
    spin  = 0; angle = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        cfg_write(plan[i].sel, plan[i].vx);
      end else begin
        typed      = '0;
        typed.spin = plan[i].want_spin;
        typed.sat  = plan[i].want_sat;
        offer(plan[i].sel[1:0], plan[i].vx, plan[i].vy, plan[i].known, typed);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      program_phase(p);
      steady = (p == STEADY_PHASE);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r  = $urandom_range(0, 99);
        op = (r < 40) ? OP_TICK : (r < 60) ? OP_FORCE : (r < 80) ? OP_TARGET : OP_SPIN;
        offer(op, pick_value(), pick_value(), 1'b0, '0);
      end
    end
    steady = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rbes_pkg.sv
hdl/rbes_front.sv
hdl/rbes_back.sv
hdl/rigid_body_euler_step_2d.sv
bench/rigid_body_euler_step_2d_test.sv
